// ===== hdl/pvt_regs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PVT sensor controller registers package
// Shared widths, offsets, codes and limits of the register front end.
// ----------------------------------------------------------------------------
package pvt_regs_pkg;

    localparam int OFFSET_W = 13;
    localparam int DATA_W   = 32;
    localparam int CODE_W   = 16;
    localparam int CFG_IDX_W = 3;

    localparam int MAX_TEMP_UNITS    = 8;
    localparam int MAX_PROC_UNITS    = 8;
    localparam int MAX_VOLT_UNITS    = 8;
    localparam int MAX_VOLT_CHANNELS = 16;

    localparam logic [31:0] UNLOCK_KEY = 32'h1acc_e551;
    localparam logic [31:0] SYNTH_MASK = 32'h01ff_ffff;
    localparam logic [31:0] IPW_MASK   = 32'h00ff_ffff;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] WIN_COMMON = 2'd0;
    localparam logic [1:0] WIN_TEMP   = 2'd1;
    localparam logic [1:0] WIN_PROC   = 2'd2;
    localparam logic [1:0] WIN_VOLT   = 2'd3;

    localparam logic [1:0] MACRO_TEMP = 2'd0;
    localparam logic [1:0] MACRO_PROC = 2'd1;
    localparam logic [1:0] MACRO_VOLT = 2'd2;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_UNIMPL = 2'd1,
        ST_RDONLY = 2'd2
    } status_t;

    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_COUNT  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROC_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_VOLT_CHANS  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COMP_IDENT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_IDENT_RESET = 3'd5;

    localparam logic [OFFSET_W-1:0] CM_COMP_ID   = 13'h000;
    localparam logic [OFFSET_W-1:0] CM_IP_CFG    = 13'h004;
    localparam logic [OFFSET_W-1:0] CM_ID_NUM    = 13'h008;
    localparam logic [OFFSET_W-1:0] CM_SCRATCH   = 13'h00c;
    localparam logic [OFFSET_W-1:0] CM_LOCK      = 13'h010;
    localparam logic [OFFSET_W-1:0] CM_LOCK_STAT = 13'h014;

    localparam logic [OFFSET_W-1:0] MC_SYNTH     = 13'h000;
    localparam logic [OFFSET_W-1:0] MC_DISABLE   = 13'h004;
    localparam logic [OFFSET_W-1:0] MC_IP_CFG    = 13'h008;
    localparam logic [OFFSET_W-1:0] MC_SIO_CMD   = 13'h00c;
    localparam logic [OFFSET_W-1:0] MC_SIO_HALT  = 13'h010;
    localparam logic [OFFSET_W-1:0] MC_SIO_CTRL  = 13'h014;
    localparam logic [OFFSET_W-1:0] MC_SMPL_CTRL = 13'h020;
    localparam logic [OFFSET_W-1:0] MC_SMPL_CLR  = 13'h024;
    localparam logic [OFFSET_W-1:0] MC_SMPL_CNT  = 13'h028;

    localparam logic [OFFSET_W-1:0] MAC_COMMON = 13'h040;
    localparam logic [OFFSET_W-1:0] VM_COMMON  = 13'h200;
    localparam int MAC_SHIFT = 6;
    localparam int VM_SHIFT  = 9;

    localparam logic [8:0] MAC_RDATA = 9'h010;
    localparam logic [8:0] MAC_DONE  = 9'h014;
    localparam logic [8:0] MAC_DATA  = 9'h018;
    localparam logic [8:0] VM_DONE   = 9'h034;
    localparam logic [8:0] VM_DATA   = 9'h040;

endpackage

// ===== hdl/pvt_regs_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PVT registers request channel
// Valid/ready channel that carries one bus access item.
// ----------------------------------------------------------------------------
interface pvt_regs_req_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [1:0]  window;
    logic [12:0] offset;
    logic [31:0] wdata;
    logic [15:0] sensor_code;

    modport source (output valid, cmd, window, offset, wdata, sensor_code, input ready);
    modport sink (input valid, cmd, window, offset, wdata, sensor_code, output ready);
endinterface

// ===== hdl/pvt_regs_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PVT registers response channel
// Valid/ready channel that carries one access result item.
// ----------------------------------------------------------------------------
interface pvt_regs_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] rdata;
    logic [1:0]  access_status;
    logic        sample_taken;

    modport source (output valid, rdata, access_status, sample_taken, input ready);
    modport sink (input valid, rdata, access_status, sample_taken, output ready);
endinterface

// ===== hdl/pvt_regs_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PVT registers configuration channel
// Valid/ready write channel that carries a register index and write data.
// ----------------------------------------------------------------------------
interface pvt_regs_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/pvt_sensor_controller_registers_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PVT sensor controller registers unit
// Register front end for the common, temperature, process and voltage
// windows, with software lock, serial IP word programming and sample counts.
// ----------------------------------------------------------------------------
// Each access item is decoded and applied to the register state in the cycle
// it is accepted, and its result lands in an output register on the same
// edge, so an item can be accepted every cycle and its result appears in the
// cycle after it. The request side stalls only while the output register
// holds a result that the response side has not taken. The configuration
// port is always ready. The id number register resets to zero, and the
// ident number reset configuration index is ignored.
module pvt_sensor_controller_registers_unit (
    input  logic            clk,
    input  logic            rst_n,
    pvt_regs_req_if.sink    req,
    pvt_regs_rsp_if.source  rsp,
    pvt_regs_cfg_if.sink    cfg
);
    import pvt_regs_pkg::*;

    logic [3:0]  temp_cnt_reg;
    logic [3:0]  proc_cnt_reg;
    logic [3:0]  volt_cnt_reg;
    logic [4:0]  chans_reg;
    logic [31:0] comp_ident_reg;

    logic [31:0] ident_reg,   ident_next;
    logic [31:0] scratch_reg, scratch_next;
    logic [31:0] lock_reg,    lock_next;
    logic        locked_reg,  locked_next;

    logic [24:0] synth_reg     [3], synth_next     [3];
    logic [31:0] disable_reg   [3], disable_next   [3];
    logic [30:0] sio_cmd_reg   [3], sio_cmd_next   [3];
    logic [31:0] sio_ctrl_reg  [3], sio_ctrl_next  [3];
    logic [2:0]  mode_reg      [3], mode_next      [3];
    logic [15:0] count_reg     [3], count_next     [3];
    logic [23:0] readback_reg  [3], readback_next  [3];
    logic [23:0] ipw_reg    [3][8], ipw_next    [3][8];

    logic        rsp_valid_reg;
    logic [31:0] rdata_reg, rdata_next;
    status_t     status_reg, status_next;
    logic        took_reg, took_next;

    logic        accept;
    logic [1:0]  m;
    logic        in_common;
    logic [6:0]  inst;
    logic [8:0]  reg_off;
    logic [5:0]  unit_sat;
    logic [31:0] unit_mask;
    logic [4:0]  chan_sat;
    logic [23:0] ctrl_word;
    logic        is_ready;
    logic        chan_hit;

    assign req.ready = !rsp_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign cfg.ready = 1'b1;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.rdata         = rdata_reg;
    assign rsp.access_status = status_reg;
    assign rsp.sample_taken  = took_reg;

    always_comb
    begin
        m = (req.window == WIN_COMMON) ? MACRO_TEMP : 2'(req.window - 2'd1);

        if (m == MACRO_VOLT)
        begin
            in_common = req.offset < VM_COMMON;
            inst      = 7'((req.offset - VM_COMMON) >> VM_SHIFT);
            reg_off   = req.offset[8:0];
        end
        else
        begin
            in_common = req.offset < MAC_COMMON;
            inst      = 7'((req.offset - MAC_COMMON) >> MAC_SHIFT);
            reg_off   = {3'b000, req.offset[5:0]};
        end

        unique case (m)
            MACRO_TEMP:
                unit_sat = ({2'b00, temp_cnt_reg} > 6'(MAX_TEMP_UNITS)) ?
                           6'(MAX_TEMP_UNITS) : {2'b00, temp_cnt_reg};
            MACRO_PROC:
                unit_sat = ({2'b00, proc_cnt_reg} > 6'(MAX_PROC_UNITS)) ?
                           6'(MAX_PROC_UNITS) : {2'b00, proc_cnt_reg};
            default:
                unit_sat = ({2'b00, volt_cnt_reg} > 6'(MAX_VOLT_UNITS)) ?
                           6'(MAX_VOLT_UNITS) : {2'b00, volt_cnt_reg};
        endcase

        unit_mask = 32'((33'd1 << unit_sat) - 33'd1);
        chan_sat  = ({2'b00, chans_reg} > 7'(MAX_VOLT_CHANNELS)) ?
                    5'(MAX_VOLT_CHANNELS) : chans_reg;
        chan_hit  = (reg_off >= VM_DATA) &&
                    ({1'b0, reg_off} < (10'(VM_DATA) + {3'b000, chan_sat, 2'b00}));

        ctrl_word = ipw_reg[m][0];
        is_ready  = synth_reg[m][24]
                 && !((inst < 7'd32) && disable_reg[m][inst[4:0]])
                 && !mode_reg[m][2]
                 && ctrl_word[1]
                 && (ctrl_word[3] || ctrl_word[8])
                 && ((m != MACRO_VOLT) || ctrl_word[10]);
    end

    always_comb
    begin
        ident_next    = ident_reg;
        scratch_next  = scratch_reg;
        lock_next     = lock_reg;
        locked_next   = locked_reg;
        synth_next    = synth_reg;
        disable_next  = disable_reg;
        sio_cmd_next  = sio_cmd_reg;
        sio_ctrl_next = sio_ctrl_reg;
        mode_next     = mode_reg;
        count_next    = count_reg;
        readback_next = readback_reg;
        ipw_next      = ipw_reg;
        rdata_next    = '0;
        status_next   = ST_OK;
        took_next     = 1'b0;

        if (req.window == WIN_COMMON)
        begin
            if (req.cmd == CMD_WRITE)
            begin
                unique case (req.offset)
                    CM_ID_NUM:  ident_next   = req.wdata;
                    CM_SCRATCH: scratch_next = req.wdata;
                    CM_LOCK:
                    begin
                        lock_next   = req.wdata;
                        locked_next = req.wdata != UNLOCK_KEY;
                    end
                    CM_COMP_ID, CM_IP_CFG, CM_LOCK_STAT: status_next = ST_RDONLY;
                    default: status_next = ST_UNIMPL;
                endcase
            end
            else
            begin
                unique case (req.offset)
                    CM_COMP_ID:   rdata_next = comp_ident_reg;
                    CM_IP_CFG:    rdata_next = {3'b000, chans_reg, 4'h0, volt_cnt_reg,
                                                4'h0, proc_cnt_reg, 4'h0, temp_cnt_reg};
                    CM_ID_NUM:    rdata_next = ident_reg;
                    CM_SCRATCH:   rdata_next = scratch_reg;
                    CM_LOCK:      rdata_next = lock_reg;
                    CM_LOCK_STAT: rdata_next = {31'd0, locked_reg};
                    default:      status_next = ST_UNIMPL;
                endcase
            end
        end
        else if (in_common)
        begin
            if (req.cmd == CMD_WRITE)
            begin
                if (!locked_reg)
                begin
                    unique case (req.offset)
                        MC_SYNTH:   synth_next[m] = 25'(req.wdata & SYNTH_MASK);
                        MC_DISABLE: disable_next[m] = req.wdata & unit_mask;
                        MC_SIO_CMD:
                        begin
                            sio_cmd_next[m] = req.wdata[30:0];
                            if (req.wdata[31])
                            begin
                                if (req.wdata[27])
                                begin
                                    ipw_next[m][req.wdata[26:24]] = 24'(req.wdata & IPW_MASK);
                                end
                                else if (!ctrl_word[8])
                                begin
                                    readback_next[m] = ipw_reg[m][req.wdata[26:24]];
                                end
                            end
                        end
                        MC_SIO_HALT:
                        begin
                            if (req.wdata[0])
                            begin
                                for (int i = 0; i < 8; i++)
                                begin
                                    ipw_next[m][i] = '0;
                                end
                                readback_next[m] = '0;
                            end
                        end
                        MC_SIO_CTRL:  sio_ctrl_next[m] = req.wdata & unit_mask;
                        MC_SMPL_CTRL: mode_next[m] = req.wdata[2:0];
                        MC_SMPL_CLR:
                        begin
                            if (req.wdata[0])
                            begin
                                count_next[m] = '0;
                            end
                        end
                        MC_IP_CFG, MC_SMPL_CNT: status_next = ST_RDONLY;
                        default: status_next = ST_UNIMPL;
                    endcase
                end
            end
            else
            begin
                unique case (req.offset)
                    MC_SYNTH:     rdata_next = {7'd0, synth_reg[m]};
                    MC_DISABLE:   rdata_next = disable_reg[m];
                    MC_IP_CFG:    rdata_next = ctrl_word[8] ? 32'd2 : 32'd0;
                    MC_SIO_CMD:   rdata_next = {1'b0, sio_cmd_reg[m]};
                    MC_SIO_HALT:  rdata_next = '0;
                    MC_SIO_CTRL:  rdata_next = sio_ctrl_reg[m];
                    MC_SMPL_CTRL: rdata_next = {29'd0, mode_reg[m]};
                    MC_SMPL_CLR:  rdata_next = '0;
                    MC_SMPL_CNT:  rdata_next = {16'd0, count_reg[m]};
                    default:      status_next = ST_UNIMPL;
                endcase
            end
        end
        else if ((req.cmd == CMD_WRITE) || (inst >= {1'b0, unit_sat}))
        begin
            status_next = ST_UNIMPL;
        end
        else
        begin
            priority if ((m != MACRO_VOLT) && (reg_off == MAC_RDATA))
            begin
                rdata_next = {8'd0, readback_reg[m]};
            end
            else if (((m != MACRO_VOLT) && (reg_off == MAC_DONE)) ||
                     ((m == MACRO_VOLT) && (reg_off == VM_DONE)))
            begin
                rdata_next = {31'd0, is_ready};
            end
            else if (((m != MACRO_VOLT) && (reg_off == MAC_DATA)) ||
                     ((m == MACRO_VOLT) && chan_hit))
            begin
                if (is_ready)
                begin
                    rdata_next = {16'd0, req.sensor_code};
                    took_next  = 1'b1;
                    if (!mode_reg[m][0] && ((count_reg[m] != 16'hffff) || !mode_reg[m][1]))
                    begin
                        count_next[m] = count_reg[m] + 16'd1;
                    end
                end
            end
            else
            begin
                status_next = ST_UNIMPL;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_cnt_reg   <= '0;
            proc_cnt_reg   <= '0;
            volt_cnt_reg   <= '0;
            chans_reg      <= '0;
            comp_ident_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_TEMP_COUNT: temp_cnt_reg   <= cfg.data[3:0];
                CFG_PROC_COUNT: proc_cnt_reg   <= cfg.data[3:0];
                CFG_VOLT_COUNT: volt_cnt_reg   <= cfg.data[3:0];
                CFG_VOLT_CHANS: chans_reg      <= cfg.data[4:0];
                CFG_COMP_IDENT: comp_ident_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ident_reg   <= '0;
            scratch_reg <= '0;
            lock_reg    <= '0;
            locked_reg  <= 1'b0;
            for (int k = 0; k < 3; k++)
            begin
                synth_reg[k]    <= '0;
                disable_reg[k]  <= '0;
                sio_cmd_reg[k]  <= '0;
                sio_ctrl_reg[k] <= '0;
                mode_reg[k]     <= '0;
                count_reg[k]    <= '0;
                readback_reg[k] <= '0;
                for (int j = 0; j < 8; j++)
                begin
                    ipw_reg[k][j] <= '0;
                end
            end
        end
        else if (accept)
        begin
            ident_reg     <= ident_next;
            scratch_reg   <= scratch_next;
            lock_reg      <= lock_next;
            locked_reg    <= locked_next;
            synth_reg     <= synth_next;
            disable_reg   <= disable_next;
            sio_cmd_reg   <= sio_cmd_next;
            sio_ctrl_reg  <= sio_ctrl_next;
            mode_reg      <= mode_next;
            count_reg     <= count_next;
            readback_reg  <= readback_next;
            ipw_reg       <= ipw_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            rsp_valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rdata_reg  <= rdata_next;
            status_reg <= status_next;
            took_reg   <= took_next;
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PVT sensor controller registers testbench
// Drives bus access items into the register front end and compares every
// result item with a predictor of the register state, through directed tests
// of the common window, the lock, sampling and serial IP programming, and
// through random traffic under several counts configurations.
// ----------------------------------------------------------------------------
module testbench;
    import pvt_regs_pkg::*;

    typedef struct packed {
        logic [31:0] rdata;
        status_t     status;
        logic        taken;
    } access_result_t;

    logic clk;
    logic rst_n;

    pvt_regs_req_if req_ch ();
    pvt_regs_rsp_if rsp_ch ();
    pvt_regs_cfg_if cfg_ch ();

    pvt_sensor_controller_registers_unit u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    logic [OFFSET_W-1:0] common_regs [6] = '{CM_COMP_ID, CM_IP_CFG, CM_ID_NUM,
                                             CM_SCRATCH, CM_LOCK, CM_LOCK_STAT};
    logic [OFFSET_W-1:0] macro_regs [9] = '{MC_SYNTH, MC_DISABLE, MC_IP_CFG,
                                            MC_SIO_CMD, MC_SIO_HALT, MC_SIO_CTRL,
                                            MC_SMPL_CTRL, MC_SMPL_CLR, MC_SMPL_CNT};

    logic [3:0]  cfg_units [3];
    logic [4:0]  cfg_chans;
    logic [31:0] cfg_comp_ident;
    logic [31:0] cfg_ident_reset;

    logic [31:0] ident_word;
    logic [31:0] scratch_reg;
    logic [31:0] lock_reg;
    logic        locked;
    logic [24:0] synth_reg [3];
    logic [31:0] disable_reg [3];
    logic [31:0] sio_cmd_reg [3];
    logic [31:0] sio_ctrl_reg [3];
    logic [2:0]  mode_reg [3];
    logic [15:0] count_reg [3];
    logic [23:0] readback_reg [3];
    logic [23:0] ip_word [24];

    access_result_t expected_results [$];
    int errors = 0;
    int burst_left = 0;
    bit hold_off_req = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic int unsigned macro_base(int m);
        return (m == MACRO_VOLT) ? VM_COMMON : MAC_COMMON;
    endfunction

    function automatic int unsigned units_built(int m);
        int unsigned lim;
        lim = (m == MACRO_TEMP) ? MAX_TEMP_UNITS :
              (m == MACRO_PROC) ? MAX_PROC_UNITS : MAX_VOLT_UNITS;
        return (cfg_units[m] > lim) ? lim : cfg_units[m];
    endfunction

    function automatic int unsigned chans_built();
        return (cfg_chans > MAX_VOLT_CHANNELS) ? MAX_VOLT_CHANNELS : cfg_chans;
    endfunction

    function automatic logic [31:0] units_mask(int m);
        return (32'd1 << units_built(m)) - 32'd1;
    endfunction

    function automatic logic [OFFSET_W-1:0] unit_offset(int m, int inst, int unsigned sub);
        return OFFSET_W'(macro_base(m) * (inst + 1) + sub);
    endfunction

    function automatic bit sensor_ready(int m, int unsigned inst);
        logic [23:0] ctrl;
        ctrl = ip_word[m * 8];
        if (!synth_reg[m][24])
            return 1'b0;
        if (inst < 32 && disable_reg[m][inst])
            return 1'b0;
        if (mode_reg[m][2])
            return 1'b0;
        if (!ctrl[1] || !(ctrl[3] || ctrl[8]))
            return 1'b0;
        return (m != MACRO_VOLT) || ctrl[10];
    endfunction

    // Applies one access to the register state and returns its result.
    function automatic access_result_t predict_access(logic wr, logic [1:0] w,
                                                      logic [12:0] off, logic [31:0] v,
                                                      logic [15:0] code);
        access_result_t r;
        int m;
        int a;
        int unsigned base;
        int unsigned inst;
        int unsigned sub;
        r.rdata  = '0;
        r.status = ST_OK;
        r.taken  = 1'b0;
        if (w == WIN_COMMON)
        begin
            if (wr)
            begin
                case (off)
                    CM_ID_NUM:  ident_word = v;
                    CM_SCRATCH: scratch_reg = v;
                    CM_LOCK:
                    begin
                        lock_reg = v;
                        locked = (v != UNLOCK_KEY);
                    end
                    CM_COMP_ID, CM_IP_CFG, CM_LOCK_STAT: r.status = ST_RDONLY;
                    default: r.status = ST_UNIMPL;
                endcase
            end
            else
            begin
                case (off)
                    CM_COMP_ID:   r.rdata = cfg_comp_ident;
                    CM_IP_CFG:    r.rdata = {3'b0, cfg_chans, 4'b0, cfg_units[MACRO_VOLT],
                                             4'b0, cfg_units[MACRO_PROC],
                                             4'b0, cfg_units[MACRO_TEMP]};
                    CM_ID_NUM:    r.rdata = ident_word;
                    CM_SCRATCH:   r.rdata = scratch_reg;
                    CM_LOCK:      r.rdata = lock_reg;
                    CM_LOCK_STAT: r.rdata = {31'b0, locked};
                    default: r.status = ST_UNIMPL;
                endcase
            end
        end
        else
        begin
            m = int'(w) - 1;
            base = macro_base(m);
            if (off < base)
            begin
                if (wr)
                begin
                    if (!locked)
                    begin
                        case (off)
                            MC_SYNTH:   synth_reg[m] = v[24:0];
                            MC_DISABLE: disable_reg[m] = v & units_mask(m);
                            MC_SIO_CMD:
                            begin
                                sio_cmd_reg[m] = {1'b0, v[30:0]};
                                if (v[31])
                                begin
                                    a = int'(v[26:24]);
                                    if (v[27])
                                        ip_word[m * 8 + a] = v[23:0];
                                    else if (!ip_word[m * 8][8])
                                        readback_reg[m] = ip_word[m * 8 + a];
                                end
                            end
                            MC_SIO_HALT:
                            begin
                                if (v[0])
                                begin
                                    for (int i = 0; i < 8; i++)
                                        ip_word[m * 8 + i] = '0;
                                    readback_reg[m] = '0;
                                end
                            end
                            MC_SIO_CTRL:  sio_ctrl_reg[m] = v & units_mask(m);
                            MC_SMPL_CTRL: mode_reg[m] = v[2:0];
                            MC_SMPL_CLR:
                            begin
                                if (v[0])
                                    count_reg[m] = '0;
                            end
                            MC_IP_CFG, MC_SMPL_CNT: r.status = ST_RDONLY;
                            default: r.status = ST_UNIMPL;
                        endcase
                    end
                end
                else
                begin
                    case (off)
                        MC_SYNTH:     r.rdata = {7'b0, synth_reg[m]};
                        MC_DISABLE:   r.rdata = disable_reg[m];
                        MC_IP_CFG:    r.rdata = ip_word[m * 8][8] ? 32'd2 : 32'd0;
                        MC_SIO_CMD:   r.rdata = sio_cmd_reg[m];
                        MC_SIO_HALT:  r.rdata = '0;
                        MC_SIO_CTRL:  r.rdata = sio_ctrl_reg[m];
                        MC_SMPL_CTRL: r.rdata = {29'b0, mode_reg[m]};
                        MC_SMPL_CLR:  r.rdata = '0;
                        MC_SMPL_CNT:  r.rdata = {16'b0, count_reg[m]};
                        default: r.status = ST_UNIMPL;
                    endcase
                end
            end
            else if (wr)
            begin
                r.status = ST_UNIMPL;
            end
            else
            begin
                inst = (off - base) / base;
                sub  = (off - base) % base;
                if (inst >= units_built(m))
                    r.status = ST_UNIMPL;
                else if (m != MACRO_VOLT && sub == MAC_RDATA)
                    r.rdata = {8'b0, readback_reg[m]};
                else if ((m != MACRO_VOLT && sub == MAC_DONE) ||
                         (m == MACRO_VOLT && sub == VM_DONE))
                    r.rdata = {31'b0, sensor_ready(m, inst)};
                else if ((m != MACRO_VOLT && sub == MAC_DATA) ||
                         (m == MACRO_VOLT && sub >= VM_DATA &&
                          sub < VM_DATA + 4 * chans_built()))
                begin
                    if (sensor_ready(m, inst))
                    begin
                        if (!mode_reg[m][0] && (count_reg[m] != 16'hffff || !mode_reg[m][1]))
                            count_reg[m] = count_reg[m] + 16'd1;
                        r.rdata = {16'b0, code};
                        r.taken = 1'b1;
                    end
                end
                else
                    r.status = ST_UNIMPL;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        access_result_t want;
        if (rst_n)
        begin
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.index)
                    CFG_TEMP_COUNT:  cfg_units[MACRO_TEMP] = cfg_ch.data[3:0];
                    CFG_PROC_COUNT:  cfg_units[MACRO_PROC] = cfg_ch.data[3:0];
                    CFG_VOLT_COUNT:  cfg_units[MACRO_VOLT] = cfg_ch.data[3:0];
                    CFG_VOLT_CHANS:  cfg_chans = cfg_ch.data[4:0];
                    CFG_COMP_IDENT:  cfg_comp_ident = cfg_ch.data;
                    CFG_IDENT_RESET: cfg_ident_reset = cfg_ch.data;
                    default: ;
                endcase
            end
            if (req_ch.valid && req_ch.ready)
                expected_results.push_back(predict_access(req_ch.cmd, req_ch.window,
                                                          req_ch.offset, req_ch.wdata,
                                                          req_ch.sensor_code));
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual rdata %h",
                             $time, rsp_ch.rdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (rsp_ch.rdata !== want.rdata)
                    begin
                        errors++;
                        $display("%0t: rdata mismatch, expected %h, actual %h",
                                 $time, want.rdata, rsp_ch.rdata);
                    end
                    if (rsp_ch.access_status !== want.status)
                    begin
                        errors++;
                        $display("%0t: access_status mismatch, expected %0d, actual %0d",
                                 $time, want.status, rsp_ch.access_status);
                    end
                    if (rsp_ch.sample_taken !== want.taken)
                    begin
                        errors++;
                        $display("%0t: sample_taken mismatch, expected %b, actual %b",
                                 $time, want.taken, rsp_ch.sample_taken);
                    end
                end
            end
        end
    end

    initial
    begin : result_sink
        int style;
        int stretch;
        int hold_left;
        style = 0;
        stretch = 0;
        hold_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (stretch == 0)
                begin
                    style = $urandom_range(0, 2);
                    stretch = $urandom_range(8, 150);
                end
                stretch--;
                case (style)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_access(input logic c, input logic [1:0] w, input logic [12:0] o,
                               input logic [31:0] d, input logic [15:0] code);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid       <= 1'b1;
        req_ch.cmd         <= c;
        req_ch.window      <= w;
        req_ch.offset      <= o;
        req_ch.wdata       <= d;
        req_ch.sensor_code <= code;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    task automatic read_reg(input logic [1:0] w, input logic [12:0] o);
        send_access(CMD_READ, w, o, $urandom(), 16'($urandom()));
    endtask

    task automatic write_reg(input logic [1:0] w, input logic [12:0] o, input logic [31:0] d);
        send_access(CMD_WRITE, w, o, d, 16'($urandom()));
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (expected_results.size() != 0);
        @(posedge clk);
    endtask

    task automatic program_counts(input logic [3:0] t, input logic [3:0] p, input logic [3:0] v,
                                  input logic [4:0] ch, input logic [31:0] ident,
                                  input logic [31:0] ident_rst);
        logic [CFG_IDX_W-1:0] idx [6];
        logic [31:0] vals [6];
        idx  = '{CFG_TEMP_COUNT, CFG_PROC_COUNT, CFG_VOLT_COUNT,
                 CFG_VOLT_CHANS, CFG_COMP_IDENT, CFG_IDENT_RESET};
        vals = '{32'(t), 32'(p), 32'(v), 32'(ch), ident, ident_rst};
        wait_idle();
        for (int i = 0; i < 6; i++)
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[i];
            cfg_ch.data  <= vals[i];
            @(posedge clk);
            while (!cfg_ch.ready)
                @(posedge clk);
        end
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_random_access();
        logic c;
        logic [1:0] w;
        logic [12:0] o;
        logic [31:0] d;
        int m;
        int pick;
        int inst;
        w = 2'($urandom_range(0, 3));
        c = 1'($urandom_range(0, 1));
        d = $urandom();
        o = 13'($urandom_range(0, 8191));
        pick = $urandom_range(0, 99);
        if (w == WIN_COMMON)
        begin
            if (pick < 80)
                o = common_regs[$urandom_range(0, 5)];
            if (c == CMD_WRITE && o == CM_LOCK && pick % 4 != 0)
                d = UNLOCK_KEY;
        end
        else
        begin
            m = int'(w) - 1;
            inst = $urandom_range(0, units_built(m));
            if (pick < 35)
            begin
                c = ($urandom_range(0, 9) == 0) ? CMD_WRITE : CMD_READ;
                if (m == MACRO_VOLT)
                    o = unit_offset(m, inst, VM_DATA + 4 * $urandom_range(0, chans_built()) +
                                    $urandom_range(0, 3));
                else
                    o = unit_offset(m, inst, MAC_DATA);
            end
            else if (pick < 45)
            begin
                c = CMD_READ;
                o = unit_offset(m, inst, (m == MACRO_VOLT) ? VM_DONE :
                                         (pick < 40) ? MAC_DONE : MAC_RDATA);
            end
            else if (pick < 88)
            begin
                o = macro_regs[$urandom_range(0, 8)];
                c = ($urandom_range(0, 9) < 7) ? CMD_WRITE : CMD_READ;
                case (o)
                    MC_SYNTH:     d[24] = ($urandom_range(0, 4) != 0);
                    MC_DISABLE:   d = ($urandom_range(0, 1) != 0) ? '0 : d;
                    MC_SIO_HALT:  d[0] = ($urandom_range(0, 6) == 0);
                    MC_SMPL_CTRL: d[2] = ($urandom_range(0, 3) == 0);
                    MC_SIO_CMD:
                    begin
                        d[31] = ($urandom_range(0, 4) != 0);
                        if ($urandom_range(0, 1) != 0)
                        begin
                            d[27] = 1'b1;
                            d[26:24] = 3'd0;
                            d[1] = 1'b1;
                            d[8] = ($urandom_range(0, 3) == 0);
                            d[3] = !d[8] || ($urandom_range(0, 1) != 0);
                            d[10] = ($urandom_range(0, 5) != 0);
                        end
                    end
                    default: ;
                endcase
            end
        end
        send_access(c, w, o, d, 16'($urandom()));
    endtask

    task automatic test_common_window();
        read_reg(WIN_COMMON, CM_COMP_ID);
        read_reg(WIN_COMMON, CM_IP_CFG);
        read_reg(WIN_COMMON, CM_ID_NUM);
        read_reg(WIN_COMMON, CM_LOCK_STAT);
        program_counts(4'd3, 4'd5, 4'd2, 5'd7, 32'hffff_ffff, 32'h8000_0001);
        read_reg(WIN_COMMON, CM_COMP_ID);
        read_reg(WIN_COMMON, CM_IP_CFG);
        write_reg(WIN_COMMON, CM_SCRATCH, 32'hffff_ffff);
        read_reg(WIN_COMMON, CM_SCRATCH);
        write_reg(WIN_COMMON, CM_ID_NUM, 32'hffff_ffff);
        read_reg(WIN_COMMON, CM_ID_NUM);
        write_reg(WIN_COMMON, CM_COMP_ID, 32'h0);
        write_reg(WIN_COMMON, CM_IP_CFG, 32'hffff_ffff);
        write_reg(WIN_COMMON, CM_LOCK_STAT, 32'h1);
        write_reg(WIN_COMMON, 13'h1ffc, 32'h1);
        read_reg(WIN_COMMON, 13'h1ffc);
        read_reg(WIN_COMMON, 13'h018);
    endtask

    task automatic test_lock();
        write_reg(WIN_COMMON, CM_LOCK, 32'h0);
        read_reg(WIN_COMMON, CM_LOCK);
        read_reg(WIN_COMMON, CM_LOCK_STAT);
        write_reg(WIN_TEMP, MC_SYNTH, 32'hffff_ffff);
        write_reg(WIN_TEMP, MC_SMPL_CNT, 32'h1);
        write_reg(WIN_TEMP, 13'h03c, 32'h1);
        read_reg(WIN_TEMP, MC_SYNTH);
        write_reg(WIN_COMMON, CM_LOCK, UNLOCK_KEY);
        read_reg(WIN_COMMON, CM_LOCK_STAT);
        write_reg(WIN_TEMP, 13'h03c, 32'h1);
        write_reg(WIN_TEMP, MC_SMPL_CNT, 32'h1);
    endtask

    task automatic test_sampling();
        write_reg(WIN_TEMP, MC_SYNTH, 32'hffff_ffff);
        write_reg(WIN_TEMP, MC_SIO_CMD, 32'h8800_050a);
        read_reg(WIN_TEMP, MC_IP_CFG);
        send_access(CMD_READ, WIN_TEMP, unit_offset(MACRO_TEMP, 0, MAC_DATA), '0, 16'hffff);
        send_access(CMD_READ, WIN_TEMP, unit_offset(MACRO_TEMP, 2, MAC_DATA), '1, 16'h0000);
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 3, MAC_DATA));
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 0, MAC_DONE));
        write_reg(WIN_TEMP, MC_SMPL_CTRL, 32'h1);
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 1, MAC_DATA));
        write_reg(WIN_TEMP, MC_SMPL_CTRL, 32'h4);
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 1, MAC_DATA));
        write_reg(WIN_TEMP, MC_SMPL_CTRL, 32'h0);
        write_reg(WIN_TEMP, MC_DISABLE, 32'hffff_ffff);
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 0, MAC_DATA));
        write_reg(WIN_TEMP, MC_DISABLE, 32'h0);
        read_reg(WIN_TEMP, MC_SMPL_CNT);
        write_reg(WIN_TEMP, MC_SMPL_CLR, 32'h1);
        read_reg(WIN_TEMP, MC_SMPL_CNT);
        write_reg(WIN_TEMP, MC_SIO_HALT, 32'h1);
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 0, MAC_DONE));

        write_reg(WIN_PROC, MC_SIO_CMD, 32'h8b00_0123);
        write_reg(WIN_PROC, MC_SIO_CMD, 32'h8300_0000);
        read_reg(WIN_PROC, unit_offset(MACRO_PROC, 0, MAC_RDATA));
        read_reg(WIN_PROC, MC_SIO_CMD);
        write_reg(WIN_PROC, MC_SIO_CTRL, 32'hffff_ffff);
        read_reg(WIN_PROC, MC_SIO_CTRL);

        write_reg(WIN_VOLT, MC_SYNTH, 32'h0100_0000);
        write_reg(WIN_VOLT, MC_SIO_CMD, 32'h8800_050a);
        read_reg(WIN_VOLT, unit_offset(MACRO_VOLT, 1, VM_DONE));
        send_access(CMD_READ, WIN_VOLT, unit_offset(MACRO_VOLT, 1, VM_DATA + 4 * 6 + 3),
                    '0, 16'h8001);
        read_reg(WIN_VOLT, unit_offset(MACRO_VOLT, 1, VM_DATA + 4 * 7));
        write_reg(WIN_VOLT, VM_COMMON, 32'h1);
    endtask

    task automatic test_back_pressure();
        hold_off_req = 1'b1;
        repeat (40) send_random_access();
        wait_idle();
    endtask

    // Below its ceiling the count keeps climbing with the saturate bit set, and it
    // goes on counting once that bit is cleared.
    task automatic test_count_hold();
        write_reg(WIN_COMMON, CM_LOCK, UNLOCK_KEY);
        write_reg(WIN_TEMP, MC_SYNTH, 32'h0100_0000);
        write_reg(WIN_TEMP, MC_DISABLE, 32'h0);
        write_reg(WIN_TEMP, MC_SIO_CMD, 32'h8800_000a);
        write_reg(WIN_TEMP, MC_SMPL_CTRL, 32'h2);
        write_reg(WIN_TEMP, MC_SMPL_CLR, 32'h1);
        repeat (40)
            send_access(CMD_READ, WIN_TEMP, unit_offset(MACRO_TEMP, 0, MAC_DATA),
                        $urandom(), 16'($urandom()));
        read_reg(WIN_TEMP, MC_SMPL_CNT);
        write_reg(WIN_TEMP, MC_SMPL_CTRL, 32'h0);
        read_reg(WIN_TEMP, unit_offset(MACRO_TEMP, 0, MAC_DATA));
        read_reg(WIN_TEMP, MC_SMPL_CNT);
    endtask

    task automatic test_random_traffic();
        program_counts(4'd0, 4'd0, 4'd0, 5'd0, $urandom(), $urandom());
        repeat (150) send_random_access();
        program_counts(4'd8, 4'd8, 4'd8, 5'd16, 32'h0, 32'hffff_ffff);
        repeat (350) send_random_access();
        program_counts(4'd15, 4'd12, 4'd9, 5'd31, $urandom(), $urandom());
        repeat (250) send_random_access();
        program_counts(4'd1, 4'd1, 4'd1, 5'd1, $urandom(), $urandom());
        repeat (250) send_random_access();
        repeat (2)
        begin
            program_counts(4'($urandom_range(0, 8)), 4'($urandom_range(0, 8)),
                           4'($urandom_range(0, 8)), 5'($urandom_range(0, 16)),
                           $urandom(), $urandom());
            repeat (250) send_random_access();
        end
    endtask

    initial
    begin
        cfg_units[MACRO_TEMP] = '0;
        cfg_units[MACRO_PROC] = '0;
        cfg_units[MACRO_VOLT] = '0;
        cfg_chans = '0;
        cfg_comp_ident = '0;
        cfg_ident_reset = '0;
        ident_word = '0;
        scratch_reg = '0;
        lock_reg = '0;
        locked = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            synth_reg[i] = '0;
            disable_reg[i] = '0;
            sio_cmd_reg[i] = '0;
            sio_ctrl_reg[i] = '0;
            mode_reg[i] = '0;
            count_reg[i] = '0;
            readback_reg[i] = '0;
        end
        foreach (ip_word[i])
            ip_word[i] = '0;

        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.cmd         <= CMD_READ;
        req_ch.window      <= WIN_COMMON;
        req_ch.offset      <= '0;
        req_ch.wdata       <= '0;
        req_ch.sensor_code <= '0;
        cfg_ch.valid       <= 1'b0;
        cfg_ch.index       <= CFG_TEMP_COUNT;
        cfg_ch.data        <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_common_window();
        test_lock();
        test_sampling();
        test_back_pressure();
        test_count_hold();
        test_random_traffic();

        wait_idle();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
